// ----- rtl/av1shp_pkg.sv -----
`timescale 1ns / 1ps

package av1shp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_PARSED      = 2'd0,
        STATUS_UNSUPPORTED = 2'd1,
        STATUS_TRUNCATED   = 2'd2
    } status_t;

    // Number of leading payload bytes kept; four bytes always decide the result.
    localparam logic [2:0] HOLD_BYTES     = 3'd4;

    // A tier bit follows the level only when the level is above this value.
    localparam logic [4:0] LEVEL_TIER_MIN = 5'd7;

endpackage

// ----- rtl/av1_sequence_header_field_parser.sv -----
`timescale 1ns / 1ps

// The result caused by an accepted byte passes through the input register, then the result
// register, before it appears on the output ports.
// Throughput: one byte per cycle while results are taken; a result left waiting in the
// result register stalls the parse stage, and the input stalls once its register is full.
// Reset (rst_n low, asynchronous) empties both registers and clears the header state,
// so the first byte after reset starts a new sequence header.
module av1_sequence_header_field_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] payload_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [2:0] profile,
    output logic [4:0] level_index,
    output logic       tier
);

    // Input register: holds one accepted item until the parse stage takes it.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_final_reg;

    // Header state. The first four payload bytes are gathered left aligned,
    // first byte in the top bits, which mirrors the bit offsets of the header.
    logic [31:0] collected_reg;
    logic [2:0]  bytes_taken_reg;
    logic        result_given_reg;

    // Result register.
    logic                 out_valid_reg;
    av1shp_pkg::status_t  out_status_reg;
    logic [2:0]           out_profile_reg;
    logic [4:0]           out_level_reg;
    logic                 out_tier_reg;

    // Parse stage signals.
    logic                 out_free;
    logic                 fire;
    logic                 take_byte;
    logic [31:0]          collected_next;
    logic [2:0]           bytes_taken_next;
    logic                 reduced_hdr;
    logic                 timing_present;
    logic [4:0]           full_level;
    logic                 decide;
    logic                 emit;
    av1shp_pkg::status_t  res_status;
    logic [4:0]           res_level;
    logic                 res_tier;

    // The result register can load when it is empty or its item leaves now.
    assign out_free = !out_valid_reg || out_ready;
    // The parse stage consumes its item whenever the result register can load,
    // so the input register frees up in the same cycle.
    assign fire     = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || fire;

    always_comb
    begin
        // A byte is stored only while the result is still open and room remains.
        take_byte      = !result_given_reg && (bytes_taken_reg < av1shp_pkg::HOLD_BYTES);
        collected_next = collected_reg;
        if (take_byte)
        begin
            case (bytes_taken_reg[1:0])
                2'd0:    collected_next[31:24] = s1_byte_reg;
                2'd1:    collected_next[23:16] = s1_byte_reg;
                2'd2:    collected_next[15:8]  = s1_byte_reg;
                default: collected_next[7:0]   = s1_byte_reg;
            endcase
        end
        bytes_taken_next = take_byte ? bytes_taken_reg + 3'd1 : bytes_taken_reg;

        // Header bit offsets 4 and 5, and the level at offsets 24 to 28.
        reduced_hdr    = collected_next[27];
        timing_present = collected_next[26];
        full_level     = collected_next[7:3];

        // The reduced header needs two bytes; timing info decides at once;
        // the full header needs all four bytes (level plus possible tier bit).
        decide = 1'b0;
        if (bytes_taken_next != 3'd0)
        begin
            if (reduced_hdr)
                decide = (bytes_taken_next >= 3'd2);
            else if (timing_present)
                decide = 1'b1;
            else
                decide = (bytes_taken_next >= av1shp_pkg::HOLD_BYTES);
        end
        decide = decide && !result_given_reg;

        res_status = av1shp_pkg::STATUS_PARSED;
        res_level  = 5'd0;
        res_tier   = 1'b0;
        if (decide)
        begin
            if (reduced_hdr)
            begin
                res_level = collected_next[26:22];
            end
            else if (timing_present)
            begin
                res_status = av1shp_pkg::STATUS_UNSUPPORTED;
            end
            else
            begin
                res_level = full_level;
                res_tier  = (full_level > av1shp_pkg::LEVEL_TIER_MIN) ? collected_next[2] : 1'b0;
            end
        end
        else
        begin
            // Only reached with an emit when the payload ends before a decision.
            res_status = av1shp_pkg::STATUS_TRUNCATED;
        end

        emit = decide || (s1_final_reg && !result_given_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= payload_byte;
            s1_final_reg <= final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collected_reg    <= 32'd0;
            bytes_taken_reg  <= 3'd0;
            result_given_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (s1_final_reg)
            begin
                // The final byte closes the header; the next byte starts a new one.
                collected_reg    <= 32'd0;
                bytes_taken_reg  <= 3'd0;
                result_given_reg <= 1'b0;
            end
            else
            begin
                collected_reg    <= collected_next;
                bytes_taken_reg  <= bytes_taken_next;
                result_given_reg <= result_given_reg || decide;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_status_reg  <= res_status;
            out_profile_reg <= collected_next[31:29];
            out_level_reg   <= res_level;
            out_tier_reg    <= res_tier;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign profile     = out_profile_reg;
    assign level_index = out_level_reg;
    assign tier        = out_tier_reg;

    // The byte count never passes the four held bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_taken_reg <= av1shp_pkg::HOLD_BYTES)
        else $error("byte count beyond held bytes");

    // A result can only have been given once at least one byte is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_given_reg |-> (bytes_taken_reg != 3'd0))
        else $error("result given with no bytes held");

    // A consumed final byte always clears the header state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_final_reg) |=> (bytes_taken_reg == 3'd0) && !result_given_reg)
        else $error("state not cleared after final byte");

    // An open header that sees its final byte must produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_final_reg && !result_given_reg) |=> out_valid_reg)
        else $error("final byte of open header gave no result");

endmodule
